[src/rsnh_pkg.sv]
package rsnh_pkg;

  localparam int MAX_SPHERES_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int SLOT_W    = 4;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int SPH_W     = 3 * COORD_W + RAD_W;
  localparam int IN_DATA_W  = 328;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [31:0] T_LOWER_RST = 32'sd66;
  localparam logic signed [31:0] T_MAX       = 32'sh7fffffff;
  localparam logic signed [31:0] T_MIN       = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPHERE_COUNT = 2'd0,
    CFG_T_LOWER      = 2'd1,
    CFG_T_UPPER      = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_DD0, MS_DD1, MS_DD2, MS_SD0, MS_SD1, MS_SD2,
    MS_SS0, MS_SS1, MS_SS2, MS_RR, MS_BB, MS_AC
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAY, ST_RD, ST_LD, ST_MUL, ST_CHK, ST_SQRT,
    ST_DIV, ST_TEST, ST_NEXT, ST_OUT
  } state_t;

  typedef struct packed {
    logic     load_ray;
    logic     load_sph;
    mul_sel_t mul_sel;
    logic     latch_abc;
    logic     sqrt_start;
    logic     div_start;
    logic     div_far;
    logic     take_t;
  } dp_cmd_t;

  typedef struct packed {
    logic disc_pos;
    logic sqrt_done;
    logic div_done;
    logic t_ok;
  } dp_stat_t;

endpackage

[src/ray_sphere_nearest_hit.sv]
// nearest ray/sphere hit over a small table of spheres, signed fixed point
//
// s_axis carries requests; s_axis_tuser is the command: 0 writes one sphere
// slot (center, radius), 1 traces a ray against slots 0..n-1, where n is
// sphere_count capped at MAX_SPHERES. a slot write produces no result. a ray
// produces one result on m_axis: tuser = hit, tdata = slot and distance t of
// the nearest hit (slot 0 and the largest t on a miss).
// per sphere, the dot products run on the one shared multiplier; when the
// discriminant is positive, the bit-serial square root and then the serial
// divider run, the divider once for each root tried (one or two). one ray is
// in flight at a time; s_axis_tready is high only between rays.
// the result sits in an output register; the next request is taken while it
// waits, and a stalled m_axis only holds the engine when a second result is
// done. reset clears control and the config registers (sphere_count 0,
// t_lower 66, t_upper max); the sphere table is undefined until written.
// config writes (cfg_we, cfg_index, cfg_data) are to be made by the user only
// while idle; the block itself does not enforce this.
module ray_sphere_nearest_hit import rsnh_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot, center_x, center_y, center_z, sphere_radius, origin_x, origin_y,
  // origin_z, dir_x, dir_y, dir_z
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit_slot, hit_distance
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // hit
  output logic                  m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int NW = $clog2(MAX_SPHERES + 1);
  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int SW = (NW > SLOT_W) ? NW : SLOT_W;

  // config registers
  logic [CNT_W-1:0]   sphere_count;
  logic signed [31:0] t_lower, t_upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
      t_lower      <= T_LOWER_RST;
      t_upper      <= T_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPHERE_COUNT: sphere_count <= cfg_data[CNT_W-1:0];
        CFG_T_LOWER:      t_lower      <= $signed(cfg_data);
        CFG_T_UPPER:      t_upper      <= $signed(cfg_data);
        default:          sphere_count <= sphere_count;
      endcase
    end
  end

  // request fields
  logic [SLOT_W-1:0] in_slot;
  logic              accept, ray_start, tbl_we;

  assign in_slot   = s_axis_tdata[3:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign ray_start = accept && s_axis_tuser;
  // writes to slots beyond the table are dropped
  assign tbl_we    = accept && !s_axis_tuser && (SW'(in_slot) < SW'(MAX_SPHERES));

  // sphere table: cx, cy, cz, radius from the low bits up
  logic [AW-1:0]    rd_addr;
  logic [SPH_W-1:0] sph_data;

  rsnh_ram #(.WIDTH(SPH_W), .DEPTH(MAX_SPHERES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_slot)),
    .wdata (s_axis_tdata[130:4]),
    .raddr (rd_addr),
    .rdata (sph_data)
  );

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               out_free, out_load, best_hit;
  logic [NW-1:0]      cur_slot, best_slot;
  logic signed [31:0] best_t;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  rsnh_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .ray_start    (ray_start),
    .sphere_count (sphere_count),
    .out_free     (out_free),
    .stat         (stat),
    .cmd          (cmd),
    .in_ready     (s_axis_tready),
    .out_load     (out_load),
    .rd_addr      (rd_addr),
    .cur_slot     (cur_slot)
  );

  rsnh_dp #(.MAX_SPHERES(MAX_SPHERES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cur_slot  (cur_slot),
    .origin_x  (s_axis_tdata[162:131]),
    .origin_y  (s_axis_tdata[194:163]),
    .origin_z  (s_axis_tdata[226:195]),
    .dir_x     (s_axis_tdata[258:227]),
    .dir_y     (s_axis_tdata[290:259]),
    .dir_z     (s_axis_tdata[322:291]),
    .sph_data  (sph_data),
    .t_lower   (t_lower),
    .t_upper   (t_upper),
    .stat      (stat),
    .best_hit  (best_hit),
    .best_slot (best_slot),
    .best_t    (best_t)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_axis_tuser <= best_hit;
      m_axis_tdata <= {4'b0000, best_t, SLOT_W'(best_slot)};
    end
  end

  // a ray in progress blocks further requests
  assert property (@(posedge clk) disable iff (rst)
    ray_start |=> !s_axis_tready)
    else $error("request taken while a ray is in progress");

  // a miss reports slot zero and the largest distance
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[3:0] == 4'd0 && $signed(m_axis_tdata[35:4]) == T_MAX))
    else $error("miss result with stray slot or distance");

  // a reported hit lies strictly inside the distance window
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      ($signed(m_axis_tdata[35:4]) > t_lower && $signed(m_axis_tdata[35:4]) < t_upper))
    else $error("hit distance outside bounds");

endmodule

[src/rsnh_ram.sv]
module rsnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/rsnh_ctrl.sv]
module rsnh_ctrl import rsnh_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF,
  localparam int NW = $clog2(MAX_SPHERES + 1),
  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ray_start,
  input  logic [CNT_W-1:0] sphere_count,
  input  logic             out_free,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd,
  output logic             in_ready,
  output logic             out_load,
  output logic [AW-1:0]    rd_addr,
  output logic [NW-1:0]    cur_slot
);

  localparam int CW = (NW > CNT_W) ? NW : CNT_W;

  state_t        state, state_next;
  logic [3:0]    step;
  logic [NW-1:0] idx;
  logic          far;
  logic [NW-1:0] n_test;
  logic          last;

  assign n_test = (CW'(sphere_count) > CW'(MAX_SPHERES)) ? NW'(MAX_SPHERES)
                                                         : NW'(sphere_count);
  assign last     = (CW'(idx) + CW'(1)) >= CW'(n_test);
  assign rd_addr  = AW'(idx);
  assign cur_slot = idx;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (ray_start) state_next = ST_RAY;
      ST_RAY:  if (step == 4'd3) state_next = (n_test == '0) ? ST_OUT : ST_RD;
      ST_RD:   state_next = ST_LD;
      ST_LD:   state_next = ST_MUL;
      ST_MUL:  if (step == 4'd11) state_next = ST_CHK;
      ST_CHK:  state_next = stat.disc_pos ? ST_SQRT : ST_NEXT;
      ST_SQRT: if (stat.sqrt_done) state_next = ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_TEST;
      ST_TEST: state_next = (stat.t_ok || far) ? ST_NEXT : ST_DIV;
      ST_NEXT: state_next = last ? ST_OUT : ST_RD;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MS_NONE;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_ray = ray_start;
      end
      ST_RAY: begin
        case (step)
          4'd0:    cmd.mul_sel = MS_DD0;
          4'd1:    cmd.mul_sel = MS_DD1;
          4'd2:    cmd.mul_sel = MS_DD2;
          default: cmd.mul_sel = MS_NONE;
        endcase
      end
      ST_LD: cmd.load_sph = 1'b1;
      ST_MUL: begin
        case (step)
          4'd0:    cmd.mul_sel = MS_SD0;
          4'd1:    cmd.mul_sel = MS_SD1;
          4'd2:    cmd.mul_sel = MS_SD2;
          4'd3:    cmd.mul_sel = MS_SS0;
          4'd4:    cmd.mul_sel = MS_SS1;
          4'd5:    cmd.mul_sel = MS_SS2;
          4'd6:    cmd.mul_sel = MS_RR;
          4'd8:    cmd.latch_abc = 1'b1;
          4'd9:    cmd.mul_sel = MS_BB;
          4'd10:   cmd.mul_sel = MS_AC;
          default: cmd.mul_sel = MS_NONE;
        endcase
      end
      ST_CHK:  cmd.sqrt_start = stat.disc_pos;
      ST_SQRT: cmd.div_start = stat.sqrt_done;
      ST_TEST: begin
        cmd.take_t    = stat.t_ok;
        cmd.div_start = !stat.t_ok && !far;
        cmd.div_far   = 1'b1;
      end
      ST_OUT:  out_load = out_free;
      default: cmd.mul_sel = MS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      idx   <= '0;
      far   <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? 4'd0 : step + 4'd1;
      if (cmd.load_ray) idx <= '0;
      else if (state == ST_NEXT) idx <= idx + NW'(1);
      if (state == ST_CHK) far <= 1'b0;
      else if (state == ST_TEST && cmd.div_start) far <= 1'b1;
    end
  end

endmodule

[src/rsnh_dp.sv]
module rsnh_dp import rsnh_pkg::*; #(
  parameter int MAX_SPHERES = MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int NW = $clog2(MAX_SPHERES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  logic [NW-1:0]             cur_slot,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic signed [COORD_W-1:0] origin_z,
  input  logic signed [COORD_W-1:0] dir_x,
  input  logic signed [COORD_W-1:0] dir_y,
  input  logic signed [COORD_W-1:0] dir_z,
  input  logic [SPH_W-1:0]          sph_data,
  input  logic signed [31:0]        t_lower,
  input  logic signed [31:0]        t_upper,
  output dp_stat_t                  stat,
  output logic                      best_hit,
  output logic [NW-1:0]             best_slot,
  output logic signed [31:0]        best_t
);

  localparam int PW  = 66;
  localparam int DVW = 34 + FRAC_BITS;
  localparam int DCW = $clog2(DVW + 1);
  localparam logic signed [PW-1:0] ACC_MAX = PW'(T_MAX);
  localparam logic signed [PW-1:0] ACC_MIN = PW'(T_MIN);
  localparam logic [DVW-1:0] QMAX_POS = DVW'(33'h07fffffff);
  localparam logic [DVW-1:0] QMAX_NEG = DVW'(33'h080000000);

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > ACC_MAX) return T_MAX;
    if (v < ACC_MIN) return T_MIN;
    return v[31:0];
  endfunction

  logic signed [31:0] ox, oy, oz, dx, dy, dz;
  logic signed [32:0] sx, sy, sz;
  logic [RAD_W-1:0]   rad;
  logic signed [32:0] mx, my;
  logic signed [PW-1:0] p, p_sh, a_acc, b_acc, c_acc, disc;
  mul_sel_t           p_sel;
  logic signed [31:0] a_s, b_s, c_s;

  // ray and sphere operands
  always_ff @(posedge clk) begin
    if (cmd.load_ray) begin
      ox <= origin_x; oy <= origin_y; oz <= origin_z;
      dx <= dir_x;    dy <= dir_y;    dz <= dir_z;
    end
    if (cmd.load_sph) begin
      sx  <= 33'(ox) - 33'($signed(sph_data[31:0]));
      sy  <= 33'(oy) - 33'($signed(sph_data[63:32]));
      sz  <= 33'(oz) - 33'($signed(sph_data[95:64]));
      rad <= sph_data[SPH_W-1:96];
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_DD0:  begin mx = 33'(dx); my = 33'(dx); end
      MS_DD1:  begin mx = 33'(dy); my = 33'(dy); end
      MS_DD2:  begin mx = 33'(dz); my = 33'(dz); end
      MS_SD0:  begin mx = sx; my = 33'(dx); end
      MS_SD1:  begin mx = sy; my = 33'(dy); end
      MS_SD2:  begin mx = sz; my = 33'(dz); end
      MS_SS0:  begin mx = sx; my = sx; end
      MS_SS1:  begin mx = sy; my = sy; end
      MS_SS2:  begin mx = sz; my = sz; end
      MS_RR:   begin mx = $signed({2'b00, rad}); my = $signed({2'b00, rad}); end
      MS_BB:   begin mx = 33'(b_s); my = 33'(b_s); end
      MS_AC:   begin mx = 33'(a_s); my = 33'(c_s); end
      default: begin mx = '0; my = '0; end
    endcase
  end

  assign p_sh = p >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    p <= mx * my;
    if (rst) p_sel <= MS_NONE;
    else     p_sel <= cmd.mul_sel;
    if (cmd.load_ray) a_acc <= '0;
    if (cmd.load_sph) begin
      b_acc <= '0;
      c_acc <= '0;
    end
    case (p_sel)
      MS_DD0, MS_DD1, MS_DD2: a_acc <= a_acc + p_sh;
      MS_SD0, MS_SD1, MS_SD2: b_acc <= b_acc + p_sh;
      MS_SS0, MS_SS1, MS_SS2: c_acc <= c_acc + p_sh;
      MS_RR:                  c_acc <= c_acc - p_sh;
      MS_BB:                  disc  <= p;
      MS_AC:                  disc  <= disc - p;
      default:                disc  <= disc;
    endcase
    if (cmd.latch_abc) begin
      a_s <= sat32(a_acc);
      b_s <= sat32(b_acc);
      c_s <= sat32(c_acc);
    end
  end

  assign stat.disc_pos = disc > PW'(0);

  // bit-serial floor square root, two radicand bits per step
  logic [63:0] sq_v, sq_r, sq_bit, sq_trial;
  logic [4:0]  sq_cnt;
  logic        sq_busy, sq_done;

  assign sq_trial = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_v    <= disc[63:0];
        sq_r    <= '0;
        sq_bit  <= 64'h4000000000000000;
        sq_cnt  <= '0;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_v >= sq_trial) begin
          sq_v <= sq_v - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
        if (sq_cnt == 5'd31) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  assign stat.sqrt_done = sq_done;

  // restoring divider, one quotient bit per cycle
  logic signed [33:0] num;
  logic [33:0]        num_mag;
  logic [DVW-1:0]     dv_q;
  logic [32:0]        dv_rem, dv_trial;
  logic [DCW-1:0]     dv_cnt;
  logic               dv_busy, dv_done, dv_neg;
  logic signed [31:0] t_val;

  assign num = cmd.div_far ? (-34'(b_s) + $signed({2'b00, sq_r[31:0]}))
                           : (-34'(b_s) - $signed({2'b00, sq_r[31:0]}));
  assign num_mag  = num[33] ? 34'(-num) : 34'(num);
  assign dv_trial = {dv_rem[31:0], dv_q[DVW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= 1'b0;
      if (cmd.div_start) begin
        if (a_s == '0) begin
          t_val   <= (num > 34'sd0) ? T_MAX : ((num < 34'sd0) ? T_MIN : 32'sd0);
          dv_done <= 1'b1;
        end else begin
          dv_q    <= DVW'(num_mag) << FRAC_BITS;
          dv_rem  <= '0;
          dv_neg  <= num[33];
          dv_cnt  <= '0;
          dv_busy <= 1'b1;
        end
      end else if (dv_busy) begin
        if (dv_cnt == DCW'(DVW)) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
          if (!dv_neg) t_val <= (dv_q > QMAX_POS) ? T_MAX : $signed(dv_q[31:0]);
          else         t_val <= (dv_q > QMAX_NEG) ? T_MIN : $signed(32'd0 - dv_q[31:0]);
        end else begin
          dv_cnt <= dv_cnt + DCW'(1);
          if (dv_trial >= {2'b00, a_s[30:0]}) begin
            dv_rem <= dv_trial - {2'b00, a_s[30:0]};
            dv_q   <= {dv_q[DVW-2:0], 1'b1};
          end else begin
            dv_rem <= dv_trial;
            dv_q   <= {dv_q[DVW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign stat.div_done = dv_done;
  assign stat.t_ok     = (t_val > t_lower) && (t_val < t_upper);

  // nearest hit so far, earlier slot kept on ties
  always_ff @(posedge clk) begin
    if (rst || cmd.load_ray) begin
      best_hit  <= 1'b0;
      best_slot <= '0;
      best_t    <= T_MAX;
    end else if (cmd.take_t && (!best_hit || t_val < best_t)) begin
      best_hit  <= 1'b1;
      best_slot <= cur_slot;
      best_t    <= t_val;
    end
  end

endmodule

[bench/tb_ray_sphere_nearest_hit.sv]
`timescale 1ns / 100ps

module tb_ray_sphere_nearest_hit;
  import rsnh_pkg::*;

  // command codes carried on s_axis_tuser
  localparam bit CMD_WRITE = 1'b0;
  localparam bit CMD_TRACE = 1'b1;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int ONE = 65536;          // 1.0 in Q16.16
  localparam int DRAIN_CYCLES = 40;    // a slot write in flight settles well within this

  typedef struct {
    bit                    cmd;
    logic [SLOT_W-1:0]     slot;
    logic signed [31:0]    cx, cy, cz;
    logic [RAD_W-1:0]      rad;
    logic signed [31:0]    ox, oy, oz, dx, dy, dz;
  } req_t;

  typedef struct {
    bit                    hit;
    logic [SLOT_W-1:0]     slot;
    logic signed [31:0]    t_hit;
  } hit_t;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    req_t                  rq;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    bit                    typed;     // expected result typed in below
    hit_t                  res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  ray_sphere_nearest_hit dut (.*);

  always #1 clk = ~clk;

  // shadow copy of the sphere table and the registers
  logic signed [31:0] tab_cx [16], tab_cy [16], tab_cz [16];
  logic [RAD_W-1:0]   tab_r  [16];
  logic [4:0]         shadow_count = 5'd0;
  logic signed [31:0] shadow_lower = T_LOWER_RST;
  logic signed [31:0] shadow_upper = T_MAX;

  hit_t  pending_hits [$];
  int    errors = 0;
  bit    calm = 1'b0;            // no idling on either side during this stretch

  function automatic longint unsigned mag_sq(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return m * m;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // t = num / a in Q16.16, saturating, a zero divisor follows the numerator sign
  function automatic longint fx_div(longint num, longint a);
    if (a == 0) return (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
    return clamp32((num * 65536) / a);
  endfunction

  function automatic bit t_window(longint t);
    return t > longint'(shadow_lower) && t < longint'(shadow_upper);
  endfunction

  // in-window distance of one ray against one table slot: the near root, else the far root
  function automatic bit sphere_t(int k, req_t rq, output longint t);
    longint s [3], d [3], a, b, c, disc, sq;
    longint unsigned ua, uc;
    s[0] = longint'(rq.ox) - longint'(tab_cx[k]);
    s[1] = longint'(rq.oy) - longint'(tab_cy[k]);
    s[2] = longint'(rq.oz) - longint'(tab_cz[k]);
    d[0] = rq.dx; d[1] = rq.dy; d[2] = rq.dz;
    ua = 0; uc = 0; b = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      ua += mag_sq(d[i]) >> 16;
      uc += mag_sq(s[i]) >> 16;
      b += (s[i] * d[i]) >>> 16;   // floor
    end
    a = clamp32(longint'(ua));
    b = clamp32(b);
    c = clamp32(longint'(uc) - longint'(mag_sq(longint'(tab_r[k])) >> 16));
    disc = b * b - a * c;
    if (disc <= 0) return 1'b0;
    sq = longint'(floor_sqrt(disc));
    t = fx_div(-b - sq, a);
    if (t_window(t)) return 1'b1;
    t = fx_div(-b + sq, a);
    return t_window(t);
  endfunction

  function automatic hit_t nearest_hit(req_t rq);
    hit_t   r;
    longint t, best;
    int     n;
    r = '{hit: 1'b0, slot: '0, t_hit: T_MAX};
    best = 0;
    n = (shadow_count > 16) ? 16 : int'(shadow_count);
    for (int k = 0; k < n; k++) begin
      if (sphere_t(k, rq, t) && (!r.hit || t < best)) begin
        r.hit = 1'b1; r.slot = k[3:0]; best = t;
      end
    end
    if (r.hit) r.t_hit = best[31:0];
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_req(req_t rq);
    return {5'b0, rq.dz, rq.dy, rq.dx, rq.oz, rq.oy, rq.ox, rq.rad, rq.cz, rq.cy, rq.cx,
            rq.slot};
  endfunction

  function automatic void table_write(req_t rq);
    tab_cx[rq.slot] = rq.cx; tab_cy[rq.slot] = rq.cy; tab_cz[rq.slot] = rq.cz;
    tab_r[rq.slot] = rq.rad;
  endfunction

  // values near the scene most of the time, any 32-bit pattern now and then
  function automatic logic signed [31:0] rnd_pos();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
  endfunction

  function automatic logic signed [31:0] rnd_dir();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return $signed($urandom_range(0, 511)) - 256;   // its square adds at most 1 to a
    if (p < 3) return $urandom;
    return $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
  endfunction

  function automatic req_t rnd_junk();
    req_t rq;
    rq.cmd = $urandom; rq.slot = $urandom;
    rq.cx = $urandom; rq.cy = $urandom; rq.cz = $urandom; rq.rad = $urandom;
    rq.ox = $urandom; rq.oy = $urandom; rq.oz = $urandom;
    rq.dx = $urandom; rq.dy = $urandom; rq.dz = $urandom;
    return rq;
  endfunction

  function automatic req_t sphere_req(int slot_no);
    req_t rq;
    rq = rnd_junk();   // ray fields are don't-care here
    rq.cmd = CMD_WRITE; rq.slot = slot_no[3:0];
    rq.cx = rnd_pos(); rq.cy = rnd_pos(); rq.cz = rnd_pos();
    rq.rad = ($urandom_range(0, 9) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 10 * ONE));
    return rq;
  endfunction

  function automatic req_t ray_req();
    req_t rq;
    rq = rnd_junk();   // sphere fields are don't-care here
    rq.cmd = CMD_TRACE;
    rq.ox = rnd_pos(); rq.oy = rnd_pos(); rq.oz = rnd_pos();
    rq.dx = rnd_dir(); rq.dy = rnd_dir(); rq.dz = rnd_dir();
    return rq;
  endfunction

  function automatic int gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // one request onto s_axis; the expectation is recorded at the accepting edge
  task automatic send(req_t rq, bit typed, hit_t res);
    int g;
    g = gap();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata = pack_req(rq);
    s_axis_tuser = rq.cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (rq.cmd == CMD_WRITE) table_write(rq);
    else pending_hits.push_back(typed ? res : nearest_hit(rq));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // registers are only written once the engine is idle
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SPHERE_COUNT: shadow_count = val[4:0];
      CFG_T_LOWER:      shadow_lower = val;
      CFG_T_UPPER:      shadow_upper = val;
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    hit_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result hit=%0d data=%h", m_axis_tuser, m_axis_tdata);
      end else begin
        e = pending_hits.pop_front();
        if (m_axis_tuser !== e.hit || m_axis_tdata[3:0] !== e.slot ||
            m_axis_tdata[35:4] !== e.t_hit || m_axis_tdata[39:36] !== 4'b0) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected hit=%0d slot=%0d t=%0d, got hit=%0d slot=%0d t=%0d",
                     e.hit, e.slot, e.t_hit, m_axis_tuser, m_axis_tdata[3:0],
                     $signed(m_axis_tdata[35:4]));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = gap();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  row_t rows [$];

  function automatic row_t wr_row(int slot_no, int cx, int cy, int cz, int r);
    row_t w;
    w = '{kind: ROW_REQ, rq: rnd_junk(), idx: '0, val: '0, typed: 1'b0, res: '{0, 0, 0}};
    w.rq.cmd = CMD_WRITE; w.rq.slot = slot_no[3:0];
    w.rq.cx = cx; w.rq.cy = cy; w.rq.cz = cz; w.rq.rad = r[30:0];
    return w;
  endfunction

  function automatic row_t ray_row(int ox, int oy, int oz, int dx, int dy, int dz, bit miss);
    row_t w;
    w = '{kind: ROW_REQ, rq: rnd_junk(), idx: '0, val: '0, typed: miss,
          res: '{1'b0, 4'd0, T_MAX}};
    w.rq.cmd = CMD_TRACE;
    w.rq.ox = ox; w.rq.oy = oy; w.rq.oz = oz; w.rq.dx = dx; w.rq.dy = dy; w.rq.dz = dz;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    row_t w;
    w = '{kind: ROW_CFG, rq: rnd_junk(), idx: idx, val: val, typed: 1'b0, res: '{0, 0, 0}};
    return w;
  endfunction

  int counts [8]          = '{3, 16, 31, 8, 1, 0, 5, 16};
  logic [31:0] lowers [8] = '{T_LOWER_RST, T_MIN, 32'd0, -32'sd5 * ONE, 32'd66, T_MAX,
                              32'd0, 32'd0};
  logic [31:0] uppers [8] = '{T_MAX, T_MAX, 32'd10 * ONE, T_MAX, T_MIN, T_MAX,
                              32'd0, 32'd0};

  initial begin
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // nothing in the table is tested right after reset: always a miss
    rows.push_back(ray_row(0, 0, 0, 0, 0, ONE, 1'b1));
    rows.push_back(wr_row(0, 0, 0, 10 * ONE, ONE));
    rows.push_back(wr_row(1, 0, 0, 10 * ONE, ONE));                // same sphere, earlier slot wins
    rows.push_back(wr_row(2, 0, 0, 0, 100 * ONE));                 // origin inside, far root
    rows.push_back(wr_row(3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    rows.push_back(wr_row(4, 32'h80000000, 32'h80000000, 32'h80000000, 0));
    rows.push_back(wr_row(5, 0, 5 * ONE, 20 * ONE, 2 * ONE));
    rows.push_back(cfg_row(CFG_SPHERE_COUNT, 32'd6));
    rows.push_back(ray_row(0, 0, 0, 0, 0, ONE, 1'b0));
    rows.push_back(ray_row(0, 0, 0, 0, 0, 0, 1'b1));               // zero direction never hits
    rows.push_back(ray_row(0, 0, 0, 0, 0, 100, 1'b0));             // a is zero, quotient saturates
    rows.push_back(ray_row(0, 0, 0, 0, 0, -100, 1'b0));
    rows.push_back(ray_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    rows.push_back(ray_row(32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
    rows.push_back(ray_row(0, 0, 30 * ONE, 0, 0, -ONE, 1'b0));
    rows.push_back(cfg_row(CFG_T_UPPER, 32'd5 * ONE));
    rows.push_back(cfg_row(CFG_UNUSED, 32'hdeadbeef));
    rows.push_back(ray_row(0, 0, 0, 0, 0, ONE, 1'b0));
    rows.push_back(cfg_row(CFG_T_LOWER, T_MIN));
    rows.push_back(cfg_row(CFG_T_UPPER, T_MAX));
    rows.push_back(ray_row(0, 0, 0, 0, 0, -ONE, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) reg_write(rows[i].idx, rows[i].val);
      else send(rows[i].rq, rows[i].typed, rows[i].res);
    end

    // fill the rest of the table before any ray may look at it
    for (int k = 6; k < 16; k++) send(sphere_req(k), 1'b0, '{0, 0, 0});

    for (int ph = 0; ph < 8; ph++) begin
      reg_write(CFG_SPHERE_COUNT, counts[ph]);
      reg_write(CFG_T_LOWER, (ph == 7) ? $urandom : lowers[ph]);
      reg_write(CFG_T_UPPER, (ph == 7) ? $urandom : (ph == 6) ? 32'd40 * ONE : uppers[ph]);
      calm = (ph % 3 == 1);
      for (int n = 0; n < 228; n++) begin
        if ($urandom_range(0, 9) < 4) send(sphere_req($urandom_range(0, 15)), 1'b0, '{0, 0, 0});
        else send(ray_req(), 1'b0, '{0, 0, 0});
      end
      calm = 1'b0;
    end

    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
